@@ rtl/sbox_pkg.sv @@
// ----------------------------------------------------------------------------
// sbox_pkg
// Widths and shared types for the segment / box overlap pipeline.
// ----------------------------------------------------------------------------
package sbox_pkg;

    // Input coordinate: signed, 4 fraction bits
    localparam int COORD_W   = 16;
    // Doubled center offset C = b + e - min - max
    localparam int CEN_W     = 18;
    // Doubled direction W = b - e and doubled extent H = max - min
    localparam int DIR_W     = 17;
    localparam int EXT_W     = 17;
    // Magnitude of W, unsigned
    localparam int ADIR_W    = 16;
    // Axis test compare width
    localparam int AXCMP_W   = 19;
    // C * W product, H * |W| product
    localparam int PROD_W    = CEN_W + DIR_W;
    localparam int HPROD_W   = EXT_W + ADIR_W + 1;
    // Cross difference, extent sum, final compare
    localparam int CROSS_W   = PROD_W + 1;
    localparam int SUM_W     = HPROD_W + 1;
    localparam int CMP_W     = CROSS_W + 1;

    // Register stages from input to result
    localparam int NUM_STAGES = 5;

    // Per-stage load enables handed to the cross-product lanes
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } sbox_adv_t;

endpackage

@@ rtl/sbox_cross.sv @@
// ----------------------------------------------------------------------------
// sbox_cross
// One cross-product separating axis lane: |Ca*Wb - Cb*Wa| > Ha*|Wb| + Hb*|Wa|,
// computed over four register stages.
// ----------------------------------------------------------------------------
module sbox_cross
(
    input  logic                              clk,
    input  sbox_pkg::sbox_adv_t               adv,
    input  logic signed [sbox_pkg::CEN_W-1:0] c_a,
    input  logic signed [sbox_pkg::CEN_W-1:0] c_b,
    input  logic signed [sbox_pkg::DIR_W-1:0] w_a,
    input  logic signed [sbox_pkg::DIR_W-1:0] w_b,
    input  logic signed [sbox_pkg::EXT_W-1:0] h_a,
    input  logic signed [sbox_pkg::EXT_W-1:0] h_b,
    input  logic        [sbox_pkg::ADIR_W-1:0] aw_a,
    input  logic        [sbox_pkg::ADIR_W-1:0] aw_b,
    output logic                              sep
);
    import sbox_pkg::*;

    logic signed [PROD_W-1:0]  prod_ab_reg, prod_ba_reg, prod_ab_next, prod_ba_next;
    logic signed [HPROD_W-1:0] hp_ab_reg, hp_ba_reg, hp_ab_next, hp_ba_next;
    logic signed [CROSS_W-1:0] diff_reg, diff_next;
    logic signed [SUM_W-1:0]   sum3_reg, sum3_next, sum4_reg;
    logic        [CROSS_W-1:0] mag_reg, mag_next;
    logic                      sep_reg, sep_next;

    // Stage 2: form the four products
    always_comb
    begin
        prod_ab_next = c_a * w_b;
        prod_ba_next = c_b * w_a;
        hp_ab_next   = h_a * $signed({1'b0, aw_b});
        hp_ba_next   = h_b * $signed({1'b0, aw_a});
    end

    // Stage 3: cross difference and extent sum
    always_comb
    begin
        diff_next = CROSS_W'(prod_ab_reg) - CROSS_W'(prod_ba_reg);
        sum3_next = SUM_W'(hp_ab_reg) + SUM_W'(hp_ba_reg);
    end

    // Stage 4: magnitude of the difference
    always_comb
    begin
        mag_next = diff_reg[CROSS_W-1] ? CROSS_W'(-diff_reg) : CROSS_W'(diff_reg);
    end

    // Stage 5: strict excess separates
    always_comb
    begin
        sep_next = $signed({1'b0, mag_reg}) > CMP_W'(sum4_reg);
    end

    // Advance payload on each stage enable
    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            prod_ab_reg <= prod_ab_next;
            prod_ba_reg <= prod_ba_next;
            hp_ab_reg   <= hp_ab_next;
            hp_ba_reg   <= hp_ba_next;
        end
        if (adv.s3)
        begin
            diff_reg <= diff_next;
            sum3_reg <= sum3_next;
        end
        if (adv.s4)
        begin
            mag_reg  <= mag_next;
            sum4_reg <= sum3_reg;
        end
        if (adv.s5)
        begin
            sep_reg <= sep_next;
        end
    end

    assign sep = sep_reg;

endmodule

@@ rtl/segment_box_overlap_test.sv @@
// ----------------------------------------------------------------------------
// segment_box_overlap_test
// Separating axis overlap test between a line segment and an axis-aligned box.
// ----------------------------------------------------------------------------
// The block takes one query per clock cycle while in_stall is low and returns
// overlaps from the last of its register stages. The five register stages
// are: doubled center, direction and extent; the axis tests and the 18x17
// multipliers of the three cross-product lanes; cross difference and extent
// sum; magnitude; final compare. A stall on the output holds the last stage
// while earlier stages keep advancing into empty slots, and in_stall rises
// only once every stage holds a transaction.
// Touching counts as overlap; an inverted box uses its negative extent as is.
module segment_box_overlap_test
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [sbox_pkg::COORD_W-1:0] seg_begin_x,
    input  logic signed [sbox_pkg::COORD_W-1:0] seg_begin_y,
    input  logic signed [sbox_pkg::COORD_W-1:0] seg_begin_z,
    input  logic signed [sbox_pkg::COORD_W-1:0] seg_end_x,
    input  logic signed [sbox_pkg::COORD_W-1:0] seg_end_y,
    input  logic signed [sbox_pkg::COORD_W-1:0] seg_end_z,
    input  logic signed [sbox_pkg::COORD_W-1:0] box_min_x,
    input  logic signed [sbox_pkg::COORD_W-1:0] box_min_y,
    input  logic signed [sbox_pkg::COORD_W-1:0] box_min_z,
    input  logic signed [sbox_pkg::COORD_W-1:0] box_max_x,
    input  logic signed [sbox_pkg::COORD_W-1:0] box_max_y,
    input  logic signed [sbox_pkg::COORD_W-1:0] box_max_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                overlaps
);
    import sbox_pkg::*;

    logic signed [COORD_W-1:0] seg_b [3];
    logic signed [COORD_W-1:0] seg_e [3];
    logic signed [COORD_W-1:0] bmin  [3];
    logic signed [COORD_W-1:0] bmax  [3];

    logic signed [CEN_W-1:0]  c_reg  [3];
    logic signed [CEN_W-1:0]  c_next [3];
    logic signed [DIR_W-1:0]  w_reg  [3];
    logic signed [DIR_W-1:0]  w_next [3];
    logic signed [EXT_W-1:0]  h_reg  [3];
    logic signed [EXT_W-1:0]  h_next [3];
    logic        [ADIR_W-1:0] aw_reg [3];
    logic        [ADIR_W-1:0] aw_next[3];

    logic [NUM_STAGES-1:0] vld_reg, vld_next;
    logic [NUM_STAGES-1:0] en;
    sbox_adv_t             adv;

    logic axis_sep_next;
    logic axis_sep2_reg, axis_sep3_reg, axis_sep4_reg, axis_sep5_reg;
    logic [2:0] cross_sep;

    // Gather the input fields by axis
    always_comb
    begin
        seg_b[0] = seg_begin_x;  seg_b[1] = seg_begin_y;  seg_b[2] = seg_begin_z;
        seg_e[0] = seg_end_x;    seg_e[1] = seg_end_y;    seg_e[2] = seg_end_z;
        bmin[0]  = box_min_x;    bmin[1]  = box_min_y;    bmin[2]  = box_min_z;
        bmax[0]  = box_max_x;    bmax[1]  = box_max_y;    bmax[2]  = box_max_z;
    end

    // Stage enables: a stage loads when it is empty or its successor moves
    always_comb
    begin
        en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || !out_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    assign adv.s2   = en[1];
    assign adv.s3   = en[2];
    assign adv.s4   = en[3];
    assign adv.s5   = en[4];
    assign in_stall = !en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: doubled center offset, direction, its magnitude, extent
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_next[i] = CEN_W'(seg_b[i]) + CEN_W'(seg_e[i])
                      - CEN_W'(bmin[i]) - CEN_W'(bmax[i]);
            w_next[i] = DIR_W'(seg_b[i]) - DIR_W'(seg_e[i]);
            h_next[i] = EXT_W'(bmax[i]) - EXT_W'(bmin[i]);
            aw_next[i] = w_next[i][DIR_W-1] ? ADIR_W'(-w_next[i]) : ADIR_W'(w_next[i]);
        end
    end

    // Stage 2: box axis tests |C| > H + |W|
    always_comb
    begin
        logic [CEN_W-1:0]          mag;
        logic signed [AXCMP_W-1:0] lim;
        axis_sep_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            mag = c_reg[i][CEN_W-1] ? CEN_W'(-c_reg[i]) : CEN_W'(c_reg[i]);
            lim = AXCMP_W'(h_reg[i]) + $signed(AXCMP_W'({1'b0, aw_reg[i]}));
            if ($signed({1'b0, mag}) > lim)
            begin
                axis_sep_next = 1'b1;
            end
        end
    end

    // Advance payload registers
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                c_reg[i]  <= c_next[i];
                w_reg[i]  <= w_next[i];
                h_reg[i]  <= h_next[i];
                aw_reg[i] <= aw_next[i];
            end
        end
        if (en[1])
        begin
            axis_sep2_reg <= axis_sep_next;
        end
        if (en[2])
        begin
            axis_sep3_reg <= axis_sep2_reg;
        end
        if (en[3])
        begin
            axis_sep4_reg <= axis_sep3_reg;
        end
        if (en[4])
        begin
            axis_sep5_reg <= axis_sep4_reg;
        end
    end

    // Cross-product lanes: (y,z), (x,z), (x,y)
    sbox_cross u_cross_yz
    (
        .clk  (clk),
        .adv  (adv),
        .c_a  (c_reg[1]),
        .c_b  (c_reg[2]),
        .w_a  (w_reg[1]),
        .w_b  (w_reg[2]),
        .h_a  (h_reg[1]),
        .h_b  (h_reg[2]),
        .aw_a (aw_reg[1]),
        .aw_b (aw_reg[2]),
        .sep  (cross_sep[0])
    );

    sbox_cross u_cross_xz
    (
        .clk  (clk),
        .adv  (adv),
        .c_a  (c_reg[0]),
        .c_b  (c_reg[2]),
        .w_a  (w_reg[0]),
        .w_b  (w_reg[2]),
        .h_a  (h_reg[0]),
        .h_b  (h_reg[2]),
        .aw_a (aw_reg[0]),
        .aw_b (aw_reg[2]),
        .sep  (cross_sep[1])
    );

    sbox_cross u_cross_xy
    (
        .clk  (clk),
        .adv  (adv),
        .c_a  (c_reg[0]),
        .c_b  (c_reg[1]),
        .w_a  (w_reg[0]),
        .w_b  (w_reg[1]),
        .h_a  (h_reg[0]),
        .h_b  (h_reg[1]),
        .aw_a (aw_reg[0]),
        .aw_b (aw_reg[1]),
        .sep  (cross_sep[2])
    );

    // Drive the result from the last stage
    assign out_valid = vld_reg[NUM_STAGES-1];
    assign overlaps  = !(axis_sep5_reg || (|cross_sep));

`ifndef NO_ASSERTIONS
    // Input stalls only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&vld_reg) && out_stall))
        else $error("input stalled with a free pipeline stage");

    // A free output keeps the pipeline moving
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is free");

    // An accepted transaction occupies the first stage next cycle
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted transaction lost at entry");

    // A held result keeps its valid in the last stage
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NUM_STAGES-1] && out_stall) |=> vld_reg[NUM_STAGES-1])
        else $error("stalled result dropped");
`endif

endmodule

@@ dv/segment_box_overlap_test_test.sv @@
// ----------------------------------------------------------------------------
// segment_box_overlap_test_test
// Stand-alone check of the segment / box separating axis overlap pipeline.
// A queue of queries (directed corner cases, then a mix of random and
// near-box shapes) feeds a clocked driver with random gaps. A clocked monitor
// stalls the output at random and compares every overlaps bit, in order,
// against a bit-exact integer model of the six separating axis tests.
// ----------------------------------------------------------------------------
module segment_box_overlap_test_test;

    import sbox_pkg::*;

    localparam int RANDOM_QUERIES = 1450;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = NUM_STAGES * 4;
    localparam int MAX_IDLE       = 6;

    // One query: segment end points and box corners, index 0/1/2 = x/y/z
    typedef struct packed {
        logic [2:0][COORD_W-1:0] seg_b;
        logic [2:0][COORD_W-1:0] seg_e;
        logic [2:0][COORD_W-1:0] box_lo;
        logic [2:0][COORD_W-1:0] box_hi;
    } query_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [COORD_W-1:0]  seg_begin_x = '0;
    logic signed [COORD_W-1:0]  seg_begin_y = '0;
    logic signed [COORD_W-1:0]  seg_begin_z = '0;
    logic signed [COORD_W-1:0]  seg_end_x = '0;
    logic signed [COORD_W-1:0]  seg_end_y = '0;
    logic signed [COORD_W-1:0]  seg_end_z = '0;
    logic signed [COORD_W-1:0]  box_min_x = '0;
    logic signed [COORD_W-1:0]  box_min_y = '0;
    logic signed [COORD_W-1:0]  box_min_z = '0;
    logic signed [COORD_W-1:0]  box_max_x = '0;
    logic signed [COORD_W-1:0]  box_max_y = '0;
    logic signed [COORD_W-1:0]  box_max_z = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       overlaps;

    query_t query_q[$];
    logic   overlap_q[$];
    query_t cur_query;

    int     total_queries = 0;
    int     sent_count = 0;
    int     got_count = 0;
    int     hit_count = 0;
    int     mismatch_count = 0;
    int     cycle_count = 0;
    int     gap_left = 0;
    int     stall_left = 0;
    bit     drain_hold = 1'b0;
    bit     can_load;
    logic   predicted;
    logic   wanted;

    segment_box_overlap_test dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .seg_begin_x (seg_begin_x),
        .seg_begin_y (seg_begin_y),
        .seg_begin_z (seg_begin_z),
        .seg_end_x   (seg_end_x),
        .seg_end_y   (seg_end_y),
        .seg_end_z   (seg_end_z),
        .box_min_x   (box_min_x),
        .box_min_y   (box_min_y),
        .box_min_z   (box_min_z),
        .box_max_x   (box_max_x),
        .box_max_y   (box_max_y),
        .box_max_z   (box_max_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .overlaps    (overlaps)
    );

    // ------------------------------------------------------------------------
    // Overlap predictor
    // ------------------------------------------------------------------------
    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic predict_overlap(query_t q);
        longint cen[3];
        longint dir[3];
        longint adir[3];
        longint ext[3];
        longint cross_val;
        longint reach;
        logic   separated;
        int     a;
        int     j;
        int     k;
        separated = 1'b0;
        // Doubled center offset, direction and extent
        for (a = 0; a < 3; a++)
        begin
            cen[a]  = longint'($signed(q.seg_b[a])) + longint'($signed(q.seg_e[a]))
                    - longint'($signed(q.box_lo[a])) - longint'($signed(q.box_hi[a]));
            dir[a]  = longint'($signed(q.seg_b[a])) - longint'($signed(q.seg_e[a]));
            adir[a] = mag(dir[a]);
            ext[a]  = longint'($signed(q.box_hi[a])) - longint'($signed(q.box_lo[a]));
        end
        // Box axes
        for (a = 0; a < 3; a++)
        begin
            if (mag(cen[a]) > ext[a] + adir[a])
                separated = 1'b1;
        end
        // Cross-product axes: a is the box axis crossed with the segment
        for (a = 0; a < 3; a++)
        begin
            j = (a == 0) ? 1 : 0;
            k = (a == 2) ? 1 : 2;
            cross_val = cen[j] * dir[k] - cen[k] * dir[j];
            reach = ext[j] * adir[k] + ext[k] * adir[j];
            if (mag(cross_val) > reach)
                separated = 1'b1;
        end
        return !separated;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [COORD_W-1:0] sat16(int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[COORD_W-1:0];
    endfunction

    function automatic int pick(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic query_t make_query(int bx, int by, int bz, int ex, int ey, int ez,
                                          int lx, int ly, int lz, int hx, int hy, int hz);
        query_t q;
        q.seg_b  = {sat16(bz), sat16(by), sat16(bx)};
        q.seg_e  = {sat16(ez), sat16(ey), sat16(ex)};
        q.box_lo = {sat16(lz), sat16(ly), sat16(lx)};
        q.box_hi = {sat16(hz), sat16(hy), sat16(hx)};
        return q;
    endfunction

    // Well-formed box with a segment scattered around it; mostly small boxes
    function automatic query_t near_query();
        query_t q;
        int     a;
        int     ctr;
        int     ext;
        int     spread;
        for (a = 0; a < 3; a++)
        begin
            ext      = ($urandom_range(0, 9) == 0) ? pick(0, 16000) : pick(0, 256);
            ctr      = pick(-20000, 20000);
            spread   = 3 * ext + 64;
            q.box_lo[a] = sat16(ctr - ext);
            q.box_hi[a] = sat16(ctr + ext);
            q.seg_b[a]  = sat16(ctr + pick(-spread, spread));
            q.seg_e[a]  = sat16(ctr + pick(-spread, spread));
        end
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Driver: present queued queries with random gaps
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            can_load = !in_valid;
            // Record the accepted transaction and draw the next gap
            if (in_valid && !in_stall)
            begin
                predicted = predict_overlap(cur_query);
                overlap_q.push_back(predicted);
                if (predicted)
                    hit_count++;
                sent_count++;
                gap_left = (sent_count[8:7] == 2'b01) ? 0 : $urandom_range(0, MAX_IDLE);
                if (sent_count == 60 || sent_count == 800)
                    drain_hold = 1'b1;
                can_load = 1'b1;
            end
            // Hold off until the pipeline has drained
            if (drain_hold && overlap_q.size() == 0)
                drain_hold = 1'b0;
            if (can_load)
            begin
                if (drain_hold)
                begin
                    in_valid <= 1'b0;
                end
                else if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (query_q.size() != 0)
                begin
                    cur_query = query_q.pop_front();
                    seg_begin_x <= cur_query.seg_b[0];
                    seg_begin_y <= cur_query.seg_b[1];
                    seg_begin_z <= cur_query.seg_b[2];
                    seg_end_x   <= cur_query.seg_e[0];
                    seg_end_y   <= cur_query.seg_e[1];
                    seg_end_z   <= cur_query.seg_e[2];
                    box_min_x   <= cur_query.box_lo[0];
                    box_min_y   <= cur_query.box_lo[1];
                    box_min_z   <= cur_query.box_lo[2];
                    box_max_x   <= cur_query.box_hi[0];
                    box_max_y   <= cur_query.box_hi[1];
                    box_max_z   <= cur_query.box_hi[2];
                    in_valid    <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each result transaction and stall at random
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (overlap_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual overlaps=%b",
                             $time, overlaps);
                    mismatch_count++;
                end
                else
                begin
                    wanted = overlap_q.pop_front();
                    if (overlaps !== wanted)
                    begin
                        $display("%0t: overlaps mismatch, expected %b actual %b",
                                 $time, wanted, overlaps);
                        mismatch_count++;
                    end
                end
                got_count++;
                stall_left = (got_count[8:7] == 2'b10) ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, overlap_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        query_t q;
        int     n;
        int     a;
        int     kind;
        int     side;

        // Directed: field extremes
        query_q.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        query_q.push_back(make_query(32767, 32767, 32767, 32767, 32767, 32767,
                                     32767, 32767, 32767, 32767, 32767, 32767));
        query_q.push_back(make_query(-32768, -32768, -32768, -32768, -32768, -32768,
                                     -32768, -32768, -32768, -32768, -32768, -32768));
        query_q.push_back(make_query(-32768, -32768, -32768, 32767, 32767, 32767,
                                     -32768, -32768, -32768, 32767, 32767, 32767));
        query_q.push_back(make_query(32767, -32768, 32767, -32768, 32767, -32768,
                                     -32768, -32768, -32768, 32767, 32767, 32767));
        query_q.push_back(make_query(-32768, 32767, -32768, 32767, -32768, 32767,
                                     -16, -16, -16, 16, 16, 16));
        query_q.push_back(make_query(-21846, 21845, -21846, 21845, -21846, 21845,
                                     21845, -21846, 21845, -21846, 21845, -21846));
        // Directed: inverted boxes, full and partial
        query_q.push_back(make_query(-32768, -32768, -32768, 32767, 32767, 32767,
                                     32767, 32767, 32767, -32768, -32768, -32768));
        query_q.push_back(make_query(0, 0, 0, 8, 8, 8, 16, -16, -16, -16, 16, 16));
        // Directed: touching a face versus just off it
        query_q.push_back(make_query(16, 0, 0, 32, 0, 0, 0, 0, 0, 16, 16, 16));
        query_q.push_back(make_query(17, 0, 0, 32, 0, 0, 0, 0, 0, 16, 16, 16));
        query_q.push_back(make_query(-40, 8, 8, -16, 8, 8, -16, -16, -16, 16, 16, 16));
        // Directed: degenerate segment inside, outside, on a corner
        query_q.push_back(make_query(5, -3, 7, 5, -3, 7, -16, -16, -16, 16, 16, 16));
        query_q.push_back(make_query(5, -30, 7, 5, -30, 7, -16, -16, -16, 16, 16, 16));
        query_q.push_back(make_query(16, 16, -16, 16, 16, -16, -16, -16, -16, 16, 16, 16));
        // Directed: only a cross axis separates, the same line through an edge, then other planes
        query_q.push_back(make_query(40, 0, 0, 0, 40, 0, -16, -16, -16, 16, 16, 16));
        query_q.push_back(make_query(32, 0, 0, 0, 32, 0, -16, -16, -16, 16, 16, 16));
        query_q.push_back(make_query(0, 0, 40, 0, 40, 0, -16, -16, -16, 16, 16, 16));
        query_q.push_back(make_query(0, 40, 0, 40, 0, 0, -16, -16, -16, 16, 16, 16));
        query_q.push_back(make_query(40, 0, 0, 0, 0, 40, -16, -16, -16, 16, 16, 16));
        query_q.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

        // Random mix of shapes
        for (n = 0; n < RANDOM_QUERIES; n++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 15)
            begin
                q = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            end
            else
            begin
                q = near_query();
                a = $urandom_range(0, 2);
                if (kind >= 70 && kind < 80)
                begin
                    // Collapse the segment to a point
                    q.seg_e = q.seg_b;
                end
                else if (kind >= 80 && kind < 90)
                begin
                    // Start on a face, leave outward, stay within the other slabs
                    side = $urandom_range(0, 1);
                    for (int b = 0; b < 3; b++)
                    begin
                        q.seg_b[b] = sat16(pick($signed(q.box_lo[b]), $signed(q.box_hi[b])));
                        q.seg_e[b] = sat16(pick($signed(q.box_lo[b]), $signed(q.box_hi[b])));
                    end
                    if (side != 0)
                    begin
                        q.seg_b[a] = q.box_hi[a];
                        q.seg_e[a] = sat16($signed(q.box_hi[a]) + pick(0, 300));
                    end
                    else
                    begin
                        q.seg_b[a] = q.box_lo[a];
                        q.seg_e[a] = sat16($signed(q.box_lo[a]) - pick(0, 300));
                    end
                end
                else if (kind >= 90)
                begin
                    // Swap the corners on one axis
                    {q.box_lo[a], q.box_hi[a]} = {q.box_hi[a], q.box_lo[a]};
                end
            end
            query_q.push_back(q);
        end
        total_queries = query_q.size();

        // Reset once
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for all queries, then all results, then let the pipe settle
        while (sent_count < total_queries)
            @(posedge clk);
        while (overlap_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d queries (%0d overlapping, %0d separated) under random gaps",
                 sent_count, hit_count, sent_count - hit_count);
        $display("and output stalls; %0d results checked, %0d mismatches",
                 got_count, mismatch_count);
        if (mismatch_count == 0 && overlap_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ segment_box_overlap_test.f @@
rtl/sbox_pkg.sv
rtl/sbox_cross.sv
rtl/segment_box_overlap_test.sv
dv/segment_box_overlap_test_test.sv
